// ===== hdl/abre_pkg.sv =====
// Package for the banked register file and exception entry block.
// Holds the action codes, mode codes, queue entry type and helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package abre_pkg;

	localparam int unsigned QueueDepth = 2;

	typedef enum logic [2:0] {
		ACT_READ_REG  = 3'd0,
		ACT_WRITE_REG = 3'd1,
		ACT_SWITCH    = 3'd2,
		ACT_EXCEPTION = 3'd3,
		ACT_READ_SPSR = 3'd4,
		ACT_WRITE_SPSR = 3'd5,
		ACT_CONDITION = 3'd6,
		ACT_WRITE_CPSR = 3'd7
	} action_t;

	localparam logic [4:0] MODE_FIQ = 5'h11;
	localparam logic [4:0] MODE_IRQ = 5'h12;
	localparam logic [4:0] MODE_SVC = 5'h13;
	localparam logic [4:0] MODE_ABT = 5'h17;
	localparam logic [4:0] MODE_UND = 5'h1B;

	localparam logic [2:0] FIQ_BANK  = 3'd0;
	localparam logic [2:0] IRQ_BANK  = 3'd1;
	localparam logic [2:0] SVC_BANK  = 3'd2;
	localparam logic [2:0] ABT_BANK  = 3'd3;
	localparam logic [2:0] UND_BANK  = 3'd4;
	localparam logic [2:0] BANK_NONE = 3'd5;

	localparam logic [1:0] EXC_IRQ       = 2'd0;
	localparam logic [1:0] EXC_SWI_ARM   = 2'd1;
	localparam logic [1:0] EXC_SWI_THUMB = 2'd2;
	localparam logic [1:0] EXC_UNDEF     = 2'd3;

	localparam logic [31:0] CPSR_RESET = 32'h0000_00D3;
	localparam logic [31:0] VEC_IRQ    = 32'h0000_0018;
	localparam logic [31:0] VEC_SWI    = 32'h0000_0008;
	localparam logic [31:0] VEC_UNDEF  = 32'h0000_0004;

	// One classified item as it travels from the front to the back part.
	typedef struct packed {
		action_t     action;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
		logic [4:0]  next_mode;
		logic [1:0]  exception_kind;
		logic [3:0]  condition;
	} item_t;

	function automatic logic [2:0] bank_of(input logic [4:0] mode);
		logic [2:0] b;
		unique case (mode)
			MODE_FIQ: b = FIQ_BANK;
			MODE_IRQ: b = IRQ_BANK;
			MODE_SVC: b = SVC_BANK;
			MODE_ABT: b = ABT_BANK;
			MODE_UND: b = UND_BANK;
			default:  b = BANK_NONE;
		endcase
		return b;
	endfunction

	function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f,
			input logic v5);
		logic n, z, c, v, r;
		n = f[3];
		z = f[2];
		c = f[1];
		v = f[0];
		unique case (cond)
			4'd0:  r = z;
			4'd1:  r = !z;
			4'd2:  r = c;
			4'd3:  r = !c;
			4'd4:  r = n;
			4'd5:  r = !n;
			4'd6:  r = v;
			4'd7:  r = !v;
			4'd8:  r = c && !z;
			4'd9:  r = !c || z;
			4'd10: r = n == v;
			4'd11: r = n != v;
			4'd12: r = !z && (n == v);
			4'd13: r = z || (n != v);
			4'd14: r = 1'b1;
			default: r = v5;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/abre_front.sv =====
// Front part: accepts items and holds them in a short queue for the back part.
// Depends on abre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module abre_front #(
	parameter int unsigned DEPTH = abre_pkg::QueueDepth
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire abre_pkg::item_t in_item,
	output logic                 item_valid,
	output abre_pkg::item_t      item,
	input  wire logic            item_take
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	abre_pkg::item_t   slot_q [DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [PW:0]       cnt_q;
	logic              do_push, do_pop;

	assign full       = (cnt_q == (PW+1)'(DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/abre_back.sv =====
// Back part: register file, banks, status words and exception entry.
// Executes one item per cycle, while its result is empty or popped, into a result register. Depends on abre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module abre_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            arch_v5,
	input  wire logic [31:0]     exception_base,
	input  wire logic            item_valid,
	input  wire abre_pkg::item_t item,
	output logic                 item_take,
	output logic                 empty,
	input  wire logic            pop,
	output logic [31:0]          read_data,
	output logic                 condition_pass,
	output logic                 spsr_present,
	output logic                 redirect,
	output logic [31:0]          fetch_address,
	output logic [31:0]          cpsr_value
);
	logic [31:0] vis_q  [16];
	logic [31:0] fiq_q  [7];
	logic [31:0] r13_q  [5];
	logic [31:0] r14_q  [5];
	logic [31:0] spsr_q [5];
	logic [31:0] cpsr_q;
	logic        res_valid_q;

	logic [31:0] vis_d  [16];
	logic [31:0] fiq_d  [7];
	logic [31:0] r13_d  [5];
	logic [31:0] r14_d  [5];
	logic [31:0] spsr_d [5];
	logic [31:0] cpsr_d;
	logic [31:0] rd_d, fetch_d;
	logic        pass_d, redir_d;
	logic        do_switch;
	logic [4:0]  sw_mode;
	logic [2:0]  cur_bank, new_bank, spsr_bank, tgt_bank;
	logic [31:0] lr, vec, pc, fetch_sum;
	logic [4:0]  tgt_mode;

	assign item_take = item_valid && (!res_valid_q || pop);
	assign empty     = !res_valid_q;

	always_comb begin
		vis_d  = vis_q;
		fiq_d  = fiq_q;
		r13_d  = r13_q;
		r14_d  = r14_q;
		spsr_d = spsr_q;
		cpsr_d = cpsr_q;
		rd_d = '0;
		fetch_d = '0;
		pass_d = 1'b0;
		redir_d = 1'b0;
		do_switch = 1'b0;
		sw_mode = item.next_mode;
		pc = vis_q[15];
		lr = pc - 32'd4;
		vec = abre_pkg::VEC_SWI;
		tgt_mode = abre_pkg::MODE_SVC;
		fetch_sum = '0;
		spsr_bank = abre_pkg::bank_of(cpsr_q[4:0]);
		tgt_bank = abre_pkg::BANK_NONE;
		cur_bank = abre_pkg::bank_of(cpsr_q[4:0]);
		new_bank = abre_pkg::BANK_NONE;
		unique case (item.action)
			abre_pkg::ACT_READ_REG:  rd_d = vis_q[item.reg_index];
			abre_pkg::ACT_WRITE_REG: vis_d[item.reg_index] = item.write_data;
			abre_pkg::ACT_SWITCH: begin
				do_switch = 1'b1;
				sw_mode = item.next_mode;
			end
			abre_pkg::ACT_EXCEPTION: begin
				if (!(item.exception_kind == abre_pkg::EXC_IRQ && cpsr_q[7])) begin
					case (item.exception_kind)
						abre_pkg::EXC_IRQ: begin
							tgt_mode = abre_pkg::MODE_IRQ;
							vec = abre_pkg::VEC_IRQ;
							lr = cpsr_q[5] ? pc : pc - 32'd4;
						end
						abre_pkg::EXC_UNDEF: begin
							tgt_mode = abre_pkg::MODE_UND;
							vec = abre_pkg::VEC_UNDEF;
						end
						abre_pkg::EXC_SWI_THUMB: lr = pc - 32'd2;
						default: ;
					endcase
					do_switch = 1'b1;
					sw_mode = tgt_mode;
					redir_d = 1'b1;
					fetch_sum = (arch_v5 ? exception_base : 32'd0) + vec;
					fetch_d = {fetch_sum[31:2], 2'b00};
				end
			end
			abre_pkg::ACT_READ_SPSR: begin
				if (spsr_bank != abre_pkg::BANK_NONE) begin
					rd_d = spsr_q[spsr_bank];
				end
			end
			abre_pkg::ACT_WRITE_SPSR: begin
				if (spsr_bank != abre_pkg::BANK_NONE) begin
					spsr_d[spsr_bank] = item.write_data;
				end
			end
			abre_pkg::ACT_CONDITION:
				pass_d = abre_pkg::cond_holds(item.condition, cpsr_q[31:28], arch_v5);
			default: begin
				do_switch = 1'b1;
				sw_mode = item.write_data[4:0];
			end
		endcase

		// The bank swap is self-inverse: undo the current mode, apply the new one.
		if (do_switch && sw_mode != cpsr_q[4:0]) begin
			new_bank = abre_pkg::bank_of(sw_mode);
			if (cur_bank == abre_pkg::FIQ_BANK) begin
				for (int i = 0; i < 7; i++) begin
					vis_d[8+i] = fiq_q[i];
					fiq_d[i]   = vis_q[8+i];
				end
			end else if (cur_bank != abre_pkg::BANK_NONE) begin
				vis_d[13] = r13_q[cur_bank];
				vis_d[14] = r14_q[cur_bank];
				r13_d[cur_bank] = vis_q[13];
				r14_d[cur_bank] = vis_q[14];
			end
			// Banks of distinct modes are disjoint, so the second swap reads the
			// bank's stored copy and the visible copy after the first swap.
			if (new_bank == abre_pkg::FIQ_BANK) begin
				for (int i = 0; i < 7; i++) begin
					fiq_d[i]   = vis_d[8+i];
					vis_d[8+i] = fiq_q[i];
				end
			end else if (new_bank != abre_pkg::BANK_NONE) begin
				r13_d[new_bank] = vis_d[13];
				r14_d[new_bank] = vis_d[14];
				vis_d[13] = r13_q[new_bank];
				vis_d[14] = r14_q[new_bank];
			end
			cpsr_d[4:0] = sw_mode;
		end

		if (redir_d) begin
			tgt_bank = abre_pkg::bank_of(tgt_mode);
			spsr_d[tgt_bank] = cpsr_q;
			cpsr_d[7] = 1'b1;
			if (item.exception_kind == abre_pkg::EXC_IRQ ||
					item.exception_kind == abre_pkg::EXC_SWI_THUMB) begin
				cpsr_d[5] = 1'b0;
			end
			vis_d[14] = lr;
			vis_d[15] = fetch_d + 32'd8;
		end
		if (item.action == abre_pkg::ACT_WRITE_CPSR) begin
			cpsr_d = item.write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) vis_q[i] <= '0;
			for (int i = 0; i < 7; i++) fiq_q[i] <= '0;
			for (int i = 0; i < 5; i++) begin
				r13_q[i]  <= '0;
				r14_q[i]  <= '0;
				spsr_q[i] <= '0;
			end
			cpsr_q      <= abre_pkg::CPSR_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				vis_q  <= vis_d;
				fiq_q  <= fiq_d;
				r13_q  <= r13_d;
				r14_q  <= r14_d;
				spsr_q <= spsr_d;
				cpsr_q <= cpsr_d;
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			read_data      <= rd_d;
			condition_pass <= pass_d;
			spsr_present   <= (abre_pkg::bank_of(cpsr_d[4:0]) != abre_pkg::BANK_NONE);
			redirect       <= redir_d;
			fetch_address  <= fetch_d;
			cpsr_value     <= cpsr_d;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/arm_banked_regs_exception_entry_core.sv =====
// Top level: banked register file with exception entry, queue-style ports.
// Depends on abre_pkg, abre_front and abre_back.
//
//   channel  handshake         payload
//   input    push / full       action reg_index write_data next_mode exception_kind condition
//   result   empty / pop       read_data condition_pass spsr_present redirect fetch_address
//                              cpsr_value
//   config   APB psel/penable  paddr pwdata prdata pready
//
// Each item passes through the front queue and is executed by the back part into
// the result registers; one item per cycle is sustained while results are popped.
// Reset sets the CPSR to supervisor mode with I and F set and clears the general, banked, SPSR and config registers.
// A pending result that is not popped stalls the back part; the front queue of
// two entries then fills and raises full.
`timescale 1ns / 1ps
`default_nettype none
module arm_banked_regs_exception_entry_core #(
	parameter int unsigned QUEUE_DEPTH = abre_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  action,
	input  wire logic [3:0]  reg_index,
	input  wire logic [31:0] write_data,
	input  wire logic [4:0]  next_mode,
	input  wire logic [1:0]  exception_kind,
	input  wire logic [3:0]  condition,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      read_data,
	output logic             condition_pass,
	output logic             spsr_present,
	output logic             redirect,
	output logic [31:0]      fetch_address,
	output logic [31:0]      cpsr_value,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam logic [2:0] ADDR_ARCH = 3'h0;
	localparam logic [2:0] ADDR_BASE = 3'h4;

	logic            arch_v5_q;
	logic [31:0]     base_q;
	abre_pkg::item_t in_item, q_item;
	logic            q_valid, q_take;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_v5_q <= 1'b0;
			base_q    <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_ARCH) begin
				arch_v5_q <= pwdata[0];
			end else if (paddr == ADDR_BASE) begin
				base_q <= pwdata;
			end
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_ARCH: prdata = {31'd0, arch_v5_q};
			ADDR_BASE: prdata = base_q;
			default:   prdata = '0;
		endcase
	end

	always_comb begin
		in_item.action         = abre_pkg::action_t'(action);
		in_item.reg_index      = reg_index;
		in_item.write_data     = write_data;
		in_item.next_mode      = next_mode;
		in_item.exception_kind = exception_kind;
		in_item.condition      = condition;
	end

	abre_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.item_valid (q_valid),
		.item       (q_item),
		.item_take  (q_take)
	);

	abre_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.arch_v5        (arch_v5_q),
		.exception_base (base_q),
		.item_valid     (q_valid),
		.item           (q_item),
		.item_take      (q_take),
		.empty          (empty),
		.pop            (pop),
		.read_data      (read_data),
		.condition_pass (condition_pass),
		.spsr_present   (spsr_present),
		.redirect       (redirect),
		.fetch_address  (fetch_address),
		.cpsr_value     (cpsr_value)
	);
endmodule
`default_nettype wire

// ===== tb/arm_banked_regs_exception_entry_core_test.sv =====
// Testbench for arm_banked_regs_exception_entry_core: directed and random register,
// mode, exception, SPSR, condition and CPSR items, checked against a predictor.
// Depends on abre_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module arm_banked_regs_exception_entry_core_test;

	localparam logic [2:0] ADDR_ARCH_V5 = 3'd0;
	localparam logic [2:0] ADDR_BASE    = 3'd4;
	localparam int unsigned IDLE_LIMIT  = 5000;

	typedef struct packed {
		logic [31:0] read_data;
		logic        condition_pass;
		logic        spsr_present;
		logic        redirect;
		logic [31:0] fetch_address;
		logic [31:0] cpsr_value;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [2:0] action = '0;
	logic [3:0] reg_index = '0;
	logic [31:0] write_data = '0;
	logic [4:0] next_mode = '0;
	logic [1:0] exception_kind = '0;
	logic [3:0] condition = '0;
	logic empty;
	logic pop = 1'b0;
	logic [31:0] read_data;
	logic condition_pass, spsr_present, redirect;
	logic [31:0] fetch_address, cpsr_value;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	arm_banked_regs_exception_entry_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.reg_index(reg_index), .write_data(write_data), .next_mode(next_mode),
		.exception_kind(exception_kind), .condition(condition), .empty(empty), .pop(pop),
		.read_data(read_data), .condition_pass(condition_pass),
		.spsr_present(spsr_present), .redirect(redirect), .fetch_address(fetch_address),
		.cpsr_value(cpsr_value), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state.
	logic [31:0] gpr [16];
	logic [31:0] banked [42];
	logic [31:0] spsr [6];
	logic [31:0] cpsr;
	logic arch_v5;
	logic [31:0] vector_base;

	result_t pending_results [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	int pop_stall = 0;

	function automatic int bank_index(input logic [4:0] m);
		case (m)
			abre_pkg::MODE_FIQ: return 0;
			abre_pkg::MODE_IRQ: return 1;
			abre_pkg::MODE_SVC: return 2;
			abre_pkg::MODE_ABT: return 3;
			abre_pkg::MODE_UND: return 4;
			default:            return 5;
		endcase
	endfunction

	function automatic void exchange_bank(input logic [4:0] m);
		int b;
		logic [31:0] t;
		b = bank_index(m);
		if (b == 0) begin
			for (int i = 0; i < 7; i++) begin
				t = banked[i];
				banked[i] = gpr[8 + i];
				gpr[8 + i] = t;
			end
		end else if (b != 5) begin
			for (int i = 5; i < 7; i++) begin
				t = banked[b * 7 + i];
				banked[b * 7 + i] = gpr[8 + i];
				gpr[8 + i] = t;
			end
		end
	endfunction

	function automatic void change_mode(input logic [4:0] m);
		if (cpsr[4:0] != m) begin
			exchange_bank(cpsr[4:0]);
			exchange_bank(m);
			cpsr[4:0] = m;
		end
	endfunction

	function automatic logic condition_met(input logic [3:0] c);
		logic n, z, cf, v;
		{n, z, cf, v} = cpsr[31:28];
		case (c)
			4'd0:  return z;
			4'd1:  return !z;
			4'd2:  return cf;
			4'd3:  return !cf;
			4'd4:  return n;
			4'd5:  return !n;
			4'd6:  return v;
			4'd7:  return !v;
			4'd8:  return cf && !z;
			4'd9:  return !cf || z;
			4'd10: return n == v;
			4'd11: return n != v;
			4'd12: return !z && (n == v);
			4'd13: return z || (n != v);
			4'd14: return 1'b1;
			default: return arch_v5;
		endcase
	endfunction

	function automatic result_t execute(input abre_pkg::action_t a, input logic [3:0] idx,
			input logic [31:0] data, input logic [4:0] m, input logic [1:0] kind,
			input logic [3:0] c);
		result_t r;
		logic [4:0] target;
		logic [31:0] vec, link, pc;
		int b;
		r = '0;
		case (a)
			abre_pkg::ACT_READ_REG:  r.read_data = gpr[idx];
			abre_pkg::ACT_WRITE_REG: gpr[idx] = data;
			abre_pkg::ACT_SWITCH:    change_mode(m);
			abre_pkg::ACT_EXCEPTION: begin
				pc = gpr[15];
				if (!(kind == abre_pkg::EXC_IRQ && cpsr[7])) begin
					if (kind == abre_pkg::EXC_IRQ) begin
						target = abre_pkg::MODE_IRQ;
						vec = abre_pkg::VEC_IRQ;
						link = cpsr[5] ? pc : pc - 32'd4;
					end else if (kind == abre_pkg::EXC_UNDEF) begin
						target = abre_pkg::MODE_UND;
						vec = abre_pkg::VEC_UNDEF;
						link = pc - 32'd4;
					end else begin
						target = abre_pkg::MODE_SVC;
						vec = abre_pkg::VEC_SWI;
						link = pc - ((kind == abre_pkg::EXC_SWI_THUMB) ? 32'd2 : 32'd4);
					end
					spsr[bank_index(target)] = cpsr;
					change_mode(target);
					cpsr[7] = 1'b1;
					if (kind == abre_pkg::EXC_IRQ || kind == abre_pkg::EXC_SWI_THUMB)
						cpsr[5] = 1'b0;
					gpr[14] = link;
					r.fetch_address = ((arch_v5 ? vector_base : 32'd0) + vec) & ~32'd3;
					gpr[15] = r.fetch_address + 32'd8;
					r.redirect = 1'b1;
				end
			end
			abre_pkg::ACT_READ_SPSR: begin
				b = bank_index(cpsr[4:0]);
				if (b != 5)
					r.read_data = spsr[b];
			end
			abre_pkg::ACT_WRITE_SPSR: begin
				b = bank_index(cpsr[4:0]);
				if (b != 5)
					spsr[b] = data;
			end
			abre_pkg::ACT_CONDITION: r.condition_pass = condition_met(c);
			default: begin
				change_mode(data[4:0]);
				cpsr = data;
			end
		endcase
		r.spsr_present = bank_index(cpsr[4:0]) != 5;
		r.cpsr_value = cpsr;
		return r;
	endfunction

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Send one item; push stays high across back-to-back transfers.
	task automatic send_item(input abre_pkg::action_t a, input logic [3:0] idx,
			input logic [31:0] data, input logic [4:0] m, input logic [1:0] kind,
			input logic [3:0] c);
		int gap;
		action <= a;
		reg_index <= idx;
		write_data <= data;
		next_mode <= m;
		exception_kind <= kind;
		condition <= c;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		pending_results.push_back(execute(a, idx, data, m, kind, c));
		gap = random_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_ARCH_V5)
			arch_v5 = value[0];
		else
			vector_base = value;
	endtask

	function automatic logic [4:0] pick_mode();
		logic [4:0] modes [7];
		modes = '{5'h10, abre_pkg::MODE_FIQ, abre_pkg::MODE_IRQ, abre_pkg::MODE_SVC,
			abre_pkg::MODE_ABT, abre_pkg::MODE_UND, 5'h1F};
		if ($urandom_range(0, 9) == 0)
			return 5'($urandom);
		return modes[$urandom_range(0, 6)];
	endfunction

	task automatic test_directed();
		send_item(abre_pkg::ACT_READ_REG, 4'd0, '0, '0, '0, '0);
		send_item(abre_pkg::ACT_WRITE_REG, 4'd0, 32'hFFFF_FFFF, '0, '0, '0);
		send_item(abre_pkg::ACT_WRITE_REG, 4'd15, 32'h0000_0002, '0, '0, '0);
		send_item(abre_pkg::ACT_WRITE_REG, 4'd13, 32'h5A5A_5A5A, '0, '0, '0);
		send_item(abre_pkg::ACT_READ_SPSR, '0, '0, '0, '0, '0);
		send_item(abre_pkg::ACT_WRITE_SPSR, '0, 32'hA5A5_A5A5, '0, '0, '0);
		// Same mode, then a mode with no bank, then user mode with no SPSR.
		send_item(abre_pkg::ACT_SWITCH, '0, '0, abre_pkg::MODE_SVC, '0, '0);
		send_item(abre_pkg::ACT_SWITCH, '0, '0, 5'h1F, '0, '0);
		send_item(abre_pkg::ACT_SWITCH, '0, '0, 5'h10, '0, '0);
		send_item(abre_pkg::ACT_READ_SPSR, '0, '0, '0, '0, '0);
		send_item(abre_pkg::ACT_WRITE_SPSR, '0, 32'hFFFF_FFFF, '0, '0, '0);
		send_item(abre_pkg::ACT_SWITCH, '0, '0, abre_pkg::MODE_FIQ, '0, '0);
		send_item(abre_pkg::ACT_READ_REG, 4'd13, '0, '0, '0, '0);
		// Masked IRQ is dropped; then an IRQ in Thumb state with I clear.
		send_item(abre_pkg::ACT_EXCEPTION, '0, '0, '0, abre_pkg::EXC_IRQ, '0);
		send_item(abre_pkg::ACT_WRITE_CPSR, '0, 32'hF000_0030, '0, '0, '0);
		send_item(abre_pkg::ACT_EXCEPTION, '0, '0, '0, abre_pkg::EXC_IRQ, '0);
		send_item(abre_pkg::ACT_WRITE_CPSR, '0, 32'h0000_0020, '0, '0, '0);
		send_item(abre_pkg::ACT_EXCEPTION, '0, '0, '0, abre_pkg::EXC_SWI_THUMB, '0);
		send_item(abre_pkg::ACT_EXCEPTION, '0, '0, '0, abre_pkg::EXC_SWI_ARM, '0);
		send_item(abre_pkg::ACT_EXCEPTION, '0, '0, '0, abre_pkg::EXC_UNDEF, '0);
		send_item(abre_pkg::ACT_READ_SPSR, '0, '0, '0, '0, '0);
		send_item(abre_pkg::ACT_READ_REG, 4'd14, '0, '0, '0, '0);
		for (int c = 0; c < 16; c++)
			send_item(abre_pkg::ACT_CONDITION, '0, '0, '0, '0, 4'(c));
	endtask

	task automatic test_random(input int count);
		abre_pkg::action_t a;
		logic [31:0] data;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (n == count / 2)
				drain();
			a = abre_pkg::action_t'($urandom_range(0, 7));
			data = $urandom;
			if (a == abre_pkg::ACT_WRITE_CPSR && $urandom_range(0, 4) != 0)
				data[4:0] = pick_mode();
			if (a == abre_pkg::ACT_WRITE_CPSR && $urandom_range(0, 1) == 0)
				data[7] = 1'b0;
			send_item(a, 4'($urandom), data, pick_mode(), 2'($urandom), 4'($urandom));
		end
		no_idle = 1'b0;
	endtask

	// Result checking and random pop stalls.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			if (pop && !empty) begin
				got = '{read_data, condition_pass, spsr_present, redirect, fetch_address,
					cpsr_value};
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: %h", got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %h, actual %h", want, got);
					end
				end
			end
			if (pop_stall > 0) begin
				pop_stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					pop_stall = random_gap();
			end
		end
	end

	// Watchdog on cycles with no transfer on any port.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("arm_banked_regs_exception_entry_core_test NOT OK");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 16; i++)
			gpr[i] = '0;
		for (int i = 0; i < 42; i++)
			banked[i] = '0;
		for (int i = 0; i < 6; i++)
			spsr[i] = '0;
		cpsr = abre_pkg::CPSR_RESET;
		arch_v5 = 1'b0;
		vector_base = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		write_register(ADDR_ARCH_V5, 32'd1);
		write_register(ADDR_BASE, 32'hFFFF_FFFF);
		test_directed();
		test_random(300);
		write_register(ADDR_BASE, $urandom);
		test_random(250);
		write_register(ADDR_ARCH_V5, 32'd0);
		write_register(ADDR_BASE, 32'hFFFF_FFF0);
		test_random(200);
		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("arm_banked_regs_exception_entry_core_test OK");
		else
			$display("arm_banked_regs_exception_entry_core_test NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
